[rtl/bsc_pkg.sv]
// shared types and constants of the banker's safety check unit
`default_nettype none

package bsc_pkg;

  localparam int unsigned AMT_W     = 16;
  localparam int unsigned WORK_W    = 20;
  localparam int unsigned PROC_ID_W = 4;
  localparam int unsigned RES_ID_W  = 3;
  localparam int unsigned PCNT_W    = 5;
  localparam int unsigned RCNT_W    = 4;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROC_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RES_COUNT  = 1'd1;

  localparam logic [PCNT_W-1:0] PROC_COUNT_RST = 5'd16;
  localparam logic [RCNT_W-1:0] RES_COUNT_RST  = 4'd8;

  typedef enum logic [1:0] {
    FUNC_LOAD_ALLOC = 2'd0,
    FUNC_LOAD_CLAIM = 2'd1,
    FUNC_LOAD_AVAIL = 2'd2,
    FUNC_CHECK      = 2'd3
  } func_e;

  typedef struct packed {
    func_e                func;
    logic [PROC_ID_W-1:0] proc_index;
    logic [RES_ID_W-1:0]  res_index;
    logic [AMT_W-1:0]     amount;
  } in_item_t;

  typedef struct packed {
    logic                 verdict;
    logic [PROC_ID_W-1:0] granted_proc;
    logic                 last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic init;
    logic next_proc;
    logic first_res;
    logic next_res;
    logic cmp;
    logic grant;
    logic new_pass;
    logic emit;
    logic unsafe;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fin_sel;
    logic i_last;
    logic j_last;
    logic fit;
    logic grant_done;
    logic granted_any;
    logic k_last;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/bankers_safety_check_unit.sv]
// top level of the banker's safety check unit
//
// usage: items enter on in_i and are taken at a rising edge with start_i high
// and busy_o low. func selects a load of one allocation, claim or available
// element, or a safety check. loads produce no result and keep busy_o low, so
// load items may follow each other every cycle while no check is running.
// a check raises busy_o and walks the processes in passes; each process
// visit passes through a select state, then a read and a compare state per
// resource examined (the matrix memories have one registered read port), and
// a grant state for a process that fits.
// results leave on res_o with a one-cycle strobe res_valid_o: the safe
// sequence, one process per cycle with last set on the final one, or a
// single unsafe verdict. the receiver cannot stall, so results are never
// held back. the final strobe comes in the first cycle with busy_o low.
// configuration (proc_count, res_count) is written through cfg_we_i,
// cfg_idx_i, cfg_data_i while the unit is idle; the unit itself does not
// enforce this, the user must keep to it.
// reset clears the controller, counters, flags and counts (16 processes,
// 8 resources); the matrix and available stores hold garbage until loaded.
`default_nettype none

module bankers_safety_check_unit #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned MAX_RES   = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire bsc_pkg::in_item_t                 in_i,
  output logic                                   busy_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [bsc_pkg::CFG_W-1:0]         cfg_data_i,
  output logic                                   res_valid_o,
  output bsc_pkg::out_item_t                     res_o
);
  import bsc_pkg::*;

  localparam int unsigned NPW = $clog2(MAX_PROCS + 1);
  localparam int unsigned NRW = $clog2(MAX_RES + 1);

  // configuration registers
  logic [PCNT_W-1:0] proc_count_q;
  logic [RCNT_W-1:0] res_count_q;
  logic [NPW-1:0]    np;
  logic [NRW-1:0]    nr;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_count_q <= PROC_COUNT_RST;
      res_count_q  <= RES_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROC_COUNT: proc_count_q <= cfg_data_i[PCNT_W-1:0];
        REG_RES_COUNT:  res_count_q  <= cfg_data_i[RCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // counts limited to 1..max
  always_comb begin
    if (proc_count_q == '0) begin
      np = NPW'(1);
    end else if (int'(proc_count_q) > MAX_PROCS) begin
      np = NPW'(MAX_PROCS);
    end else begin
      np = NPW'(proc_count_q);
    end
    if (res_count_q == '0) begin
      nr = NRW'(1);
    end else if (int'(res_count_q) > MAX_RES) begin
      nr = NRW'(MAX_RES);
    end else begin
      nr = NRW'(res_count_q);
    end
  end

  // sequencing
  bsc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (in_i.func),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // stores, working vector and result register
  bsc_datapath #(
    .MAX_PROCS (MAX_PROCS),
    .MAX_RES   (MAX_RES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .np_i        (np),
    .nr_i        (nr),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

[rtl/bsc_ctrl.sv]
// sequencing state machine of the safety check
`default_nettype none

module bsc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire bsc_pkg::func_e    func_i,
  input  wire bsc_pkg::dp_sts_t  sts_i,
  output bsc_pkg::ctrl_cmd_t     cmd_o,
  output logic                   busy_o
);
  import bsc_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_INIT     = 9'b000000010,
    ST_SELECT   = 9'b000000100,
    ST_READ     = 9'b000001000,
    ST_CMP      = 9'b000010000,
    ST_GRANT    = 9'b000100000,
    ST_PASS_END = 9'b001000000,
    ST_UNSAFE   = 9'b010000000,
    ST_EMIT     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (func_i == FUNC_CHECK) begin
            state_d = ST_INIT;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_SELECT;
      end
      ST_SELECT: begin
        if (sts_i.fin_sel) begin
          if (sts_i.i_last) begin
            state_d = ST_PASS_END;
          end else begin
            cmd_o.next_proc = 1'b1;
          end
        end else begin
          cmd_o.first_res = 1'b1;
          state_d         = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        if (!sts_i.fit) begin
          if (sts_i.i_last) begin
            state_d = ST_PASS_END;
          end else begin
            cmd_o.next_proc = 1'b1;
            state_d         = ST_SELECT;
          end
        end else if (sts_i.j_last) begin
          state_d = ST_GRANT;
        end else begin
          cmd_o.next_res = 1'b1;
          state_d        = ST_READ;
        end
      end
      ST_GRANT: begin
        cmd_o.grant = 1'b1;
        if (sts_i.grant_done) begin
          state_d = ST_EMIT;
        end else if (sts_i.i_last) begin
          state_d = ST_PASS_END;
        end else begin
          cmd_o.next_proc = 1'b1;
          state_d         = ST_SELECT;
        end
      end
      ST_PASS_END: begin
        if (sts_i.granted_any) begin
          cmd_o.new_pass = 1'b1;
          state_d        = ST_SELECT;
        end else begin
          state_d = ST_UNSAFE;
        end
      end
      ST_UNSAFE: begin
        cmd_o.unsafe = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.k_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

[rtl/bsc_datapath.sv]
// stores, working vector, counters and result register of the safety check
`default_nettype none

module bsc_datapath #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned MAX_RES   = 8,
  localparam int unsigned PIW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
  localparam int unsigned RIW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1,
  localparam int unsigned NPW = $clog2(MAX_PROCS + 1),
  localparam int unsigned NRW = $clog2(MAX_RES + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bsc_pkg::in_item_t    in_i,
  input  wire logic [NPW-1:0]       np_i,
  input  wire logic [NRW-1:0]       nr_i,
  input  wire bsc_pkg::ctrl_cmd_t   cmd_i,
  output bsc_pkg::dp_sts_t          sts_o,
  output logic                      res_valid_o,
  output bsc_pkg::out_item_t        res_o
);
  import bsc_pkg::*;

  localparam int unsigned DEPTH = MAX_PROCS * MAX_RES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // matrix memories and sequence memory
  logic [AMT_W-1:0]     alloc_mem [DEPTH];
  logic [AMT_W-1:0]     claim_mem [DEPTH];
  logic [PROC_ID_W-1:0] seq_mem   [MAX_PROCS];
  logic [AMT_W-1:0]     alloc_rd_q, claim_rd_q;

  logic [AMT_W-1:0]  avail_q [MAX_RES];
  logic [WORK_W-1:0] work_q  [MAX_RES];
  logic [AMT_W-1:0]  row_q   [MAX_RES];
  logic [WORK_W-1:0] work_add [MAX_RES];
  logic [WORK_W:0]   work_sum [MAX_RES];

  logic [MAX_PROCS-1:0] fin_q;
  logic [PIW-1:0]       i_q, k_q;
  logic [RIW-1:0]       j_q;
  logic [NPW-1:0]       done_q;
  logic                 granted_q;

  logic                 vld_q;
  out_item_t            res_q;

  logic [AW-1:0]        wr_addr, rd_addr;
  logic                 mat_ok, res_ok;
  logic signed [AMT_W:0]  need;
  logic signed [WORK_W:0] need_x;
  logic [WORK_W-1:0]      work_j;

  assign res_ok  = (int'(in_i.res_index) < MAX_RES);
  assign mat_ok  = res_ok && (int'(in_i.proc_index) < MAX_PROCS);
  assign wr_addr = AW'(int'(in_i.proc_index) * MAX_RES + int'(in_i.res_index));
  assign rd_addr = AW'(int'(i_q) * MAX_RES + int'(j_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && mat_ok && (in_i.func == FUNC_LOAD_ALLOC)) begin
      alloc_mem[wr_addr] <= in_i.amount;
    end
    alloc_rd_q <= alloc_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && mat_ok && (in_i.func == FUNC_LOAD_CLAIM)) begin
      claim_mem[wr_addr] <= in_i.amount;
    end
    claim_rd_q <= claim_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && res_ok && (in_i.func == FUNC_LOAD_AVAIL)) begin
      avail_q[RIW'(in_i.res_index)] <= in_i.amount;
    end
  end

  // signed need against the working vector
  assign need   = $signed({1'b0, claim_rd_q}) - $signed({1'b0, alloc_rd_q});
  assign need_x = (WORK_W+1)'(need);
  assign work_j = work_q[j_q];

  always_comb begin
    for (int k = 0; k < MAX_RES; k++) begin
      work_sum[k] = (WORK_W+1)'(work_q[k]) + (WORK_W+1)'(row_q[k]);
      work_add[k] = work_sum[k][WORK_W] ? {WORK_W{1'b1}} : work_sum[k][WORK_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      row_q[j_q] <= alloc_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_RES; k++) begin
        work_q[k] <= '0;
      end
    end else if (cmd_i.init) begin
      for (int k = 0; k < MAX_RES; k++) begin
        work_q[k] <= (k < int'(nr_i)) ? WORK_W'(avail_q[k]) : '0;
      end
    end else if (cmd_i.grant) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (k < int'(nr_i)) begin
          work_q[k] <= work_add[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grant) begin
      seq_mem[done_q[PIW-1:0]] <= PROC_ID_W'(i_q);
    end
  end

  // counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      done_q    <= '0;
      granted_q <= 1'b0;
    end else begin
      if (cmd_i.init) begin
        fin_q     <= '0;
        i_q       <= '0;
        k_q       <= '0;
        done_q    <= '0;
        granted_q <= 1'b0;
      end
      if (cmd_i.next_proc) begin
        i_q <= i_q + PIW'(1);
      end
      if (cmd_i.new_pass) begin
        i_q       <= '0;
        granted_q <= 1'b0;
      end
      if (cmd_i.first_res) begin
        j_q <= '0;
      end
      if (cmd_i.next_res) begin
        j_q <= j_q + RIW'(1);
      end
      if (cmd_i.grant) begin
        fin_q[i_q] <= 1'b1;
        done_q     <= done_q + NPW'(1);
        granted_q  <= 1'b1;
      end
      if (cmd_i.emit) begin
        k_q <= k_q + PIW'(1);
      end
    end
  end

  // result register, one strobe per result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cmd_i.emit || cmd_i.unsafe;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.unsafe) begin
      res_q.verdict      <= 1'b1;
      res_q.granted_proc <= '0;
      res_q.last         <= 1'b1;
    end else if (cmd_i.emit) begin
      res_q.verdict      <= 1'b0;
      res_q.granted_proc <= seq_mem[k_q];
      res_q.last         <= sts_o.k_last;
    end
  end

  assign res_valid_o = vld_q;
  assign res_o       = res_q;

  always_comb begin
    sts_o             = '0;
    sts_o.fin_sel     = fin_q[i_q];
    sts_o.i_last      = (NPW'(i_q) == (np_i - NPW'(1)));
    sts_o.j_last      = (NRW'(j_q) == (nr_i - NRW'(1)));
    sts_o.fit         = (need_x <= $signed({1'b0, work_j}));
    sts_o.grant_done  = (NPW'(done_q + NPW'(1)) == np_i);
    sts_o.granted_any = granted_q;
    sts_o.k_last      = (NPW'(k_q) == (np_i - NPW'(1)));
  end

  a_grant_unfinished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grant |-> !fin_q[i_q])
    else $error("grant of a process already finished");

  a_emit_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit || cmd_i.unsafe) |=> vld_q)
    else $error("result command without strobe");

  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && res_q.last) |=> !vld_q)
    else $error("result strobe after last item");

  a_unsafe_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && res_q.verdict) |-> (res_q.last && (res_q.granted_proc == '0)))
    else $error("unsafe verdict malformed");

endmodule

`default_nettype wire
